// ===== hw/rtl/upmix_pkg.sv =====
// Shared types, constants and coefficient table of the stereo to 5.1 upmixer.
package upmix_pkg;

   localparam int TAPS        = 50;
   localparam int SAMPLE_BITS = 24;
   localparam int GAIN_BITS   = 16;
   localparam int COEF_BITS   = 24;
   localparam int COEF_FRAC   = 23;
   localparam int ROM_SIZE    = 50;
   localparam int ROM_BITS    = $clog2(ROM_SIZE);

   // tap index and fill count must also hold the value TAPS
   localparam int TAP_BITS      = $clog2(TAPS + 1);
   localparam int RAM_ADDR_BITS = TAP_BITS + 1;
   localparam int RAM_DEPTH     = 2 ** RAM_ADDR_BITS;

   localparam int MUL_B_BITS = (COEF_BITS > GAIN_BITS + 1) ? COEF_BITS : GAIN_BITS + 1;
   localparam int PROD_BITS  = SAMPLE_BITS + MUL_B_BITS;
   localparam int ACC_BITS   = SAMPLE_BITS + COEF_BITS + TAP_BITS;

   localparam int CSR_INDEX_BITS = 8;
   localparam int CSR_DATA_BITS  = GAIN_BITS;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] REG_LEFT_GAIN   = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] REG_RIGHT_GAIN  = CSR_INDEX_BITS'(1);
   localparam logic [CSR_INDEX_BITS-1:0] REG_ENABLE      = CSR_INDEX_BITS'(2);
   localparam logic [CSR_INDEX_BITS-1:0] REG_OUTPUT_MODE = CSR_INDEX_BITS'(3);

   localparam logic [GAIN_BITS-1:0] GAIN_RESET = GAIN_BITS'(41350);

   // output modes
   localparam logic [1:0] MODE_SIX    = 2'd0;
   localparam logic [1:0] MODE_STEREO = 2'd1;
   localparam logic [1:0] MODE_QUAD   = 2'd2;

   localparam logic [2:0] CH_TWO  = 3'd2;
   localparam logic [2:0] CH_FOUR = 3'd4;
   localparam logic [2:0] CH_SIX  = 3'd6;

   localparam logic signed [ACC_BITS-1:0] SAMPLE_MAX =
      ACC_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
   localparam logic signed [ACC_BITS-1:0] SAMPLE_MIN = -SAMPLE_MAX - ACC_BITS'(1);
   localparam logic signed [PROD_BITS-1:0] GAIN_HALF = PROD_BITS'(1) <<< (GAIN_BITS - 1);
   localparam logic signed [ACC_BITS-1:0]  FIR_HALF  = ACC_BITS'(1) <<< (COEF_FRAC - 1);

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

   typedef struct packed {
      sample_type left_in;
      sample_type right_in;
   } req_type;

   typedef struct packed {
      sample_type front_left;
      sample_type front_right;
      sample_type surround_left;
      sample_type surround_right;
      sample_type center_out;
      sample_type low_freq_out;
      logic [2:0] channels_used;
      logic       clipped;
   } rsp_type;

   typedef struct packed {
      sample_type value;
      logic       clip;
   } sat_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_GAIN_L,
      ST_GAIN_R,
      ST_WRITE_L,
      ST_WRITE_R,
      ST_MAC,
      ST_DRAIN,
      ST_SCALE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                load_in;
      logic                gain;
      logic                gain_ch;
      logic                wr_en;
      logic                wr_ch;
      logic                advance;
      logic                clr_acc;
      logic                issue;
      logic                rd_ch;
      logic [TAP_BITS-1:0] tap;
      logic                scale;
      logic                load_out;
   } cmd_type;

   typedef struct packed {
      logic enable;
      logic busy;
   } status_type;

   localparam logic signed [COEF_BITS-1:0] TAP_ROM [ROM_SIZE] = '{
      -24'sd108370, -24'sd114498, -24'sd120533, -24'sd126456, -24'sd132247,
      -24'sd137890, -24'sd143365, -24'sd148656, -24'sd153744, -24'sd158614,
      -24'sd163250, -24'sd167636, -24'sd171759, -24'sd175604, -24'sd179160,
      -24'sd182413, -24'sd185354, -24'sd187972, -24'sd190259, -24'sd192208,
      -24'sd193811, -24'sd195063, -24'sd195961, -24'sd196501,  24'sd8195044,
      -24'sd196501, -24'sd195961, -24'sd195063, -24'sd193811, -24'sd192208,
      -24'sd190259, -24'sd187972, -24'sd185354, -24'sd182413, -24'sd179160,
      -24'sd175604, -24'sd171759, -24'sd167636, -24'sd163250, -24'sd158614,
      -24'sd153744, -24'sd148656, -24'sd143365, -24'sd137890, -24'sd132247,
      -24'sd126456, -24'sd120533, -24'sd114498, -24'sd108370, -24'sd102167
   };

   // taps past the end of the table read as zero
   function automatic logic signed [COEF_BITS-1:0] tap_coef(input logic [TAP_BITS-1:0] idx);
      logic signed [COEF_BITS-1:0] coef;
      coef = '0;
      if (idx < TAP_BITS'(ROM_SIZE)) begin
         coef = TAP_ROM[ROM_BITS'(idx)];
      end
      return coef;
   endfunction

   function automatic sat_type sat_sample(input logic signed [ACC_BITS-1:0] v);
      sat_type r;
      if (v > SAMPLE_MAX) begin
         r.value = SAMPLE_MAX[SAMPLE_BITS-1:0];
         r.clip  = 1'b1;
      end else if (v < SAMPLE_MIN) begin
         r.value = SAMPLE_MIN[SAMPLE_BITS-1:0];
         r.clip  = 1'b1;
      end else begin
         r.value = v[SAMPLE_BITS-1:0];
         r.clip  = 1'b0;
      end
      return r;
   endfunction

endpackage

// ===== hw/rtl/upmix_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module upmix_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/upmix_ctrl.sv =====
// Sequencer of the upmixer: handshakes, gain, delay-line write and tap loop.
module upmix_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  upmix_pkg::status_type  status,
   output upmix_pkg::cmd_type     cmd
);
   import upmix_pkg::*;

   state_type           state_ff, state_in;
   logic [TAP_BITS-1:0] tap_ff, tap_in;
   logic                ch_ff, ch_in;
   logic                rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tap_ff       <= '0;
         ch_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tap_ff       <= tap_in;
         ch_ff        <= ch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      tap_in       = tap_ff;
      ch_in        = ch_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      cmd          = '0;
      cmd.tap      = tap_ff;
      cmd.rd_ch    = ch_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in    = status.enable ? ST_GAIN_L : ST_DONE;
            end
         end
         ST_GAIN_L: begin
            cmd.gain = 1'b1;
            state_in = ST_GAIN_R;
         end
         ST_GAIN_R: begin
            cmd.gain    = 1'b1;
            cmd.gain_ch = 1'b1;
            state_in    = ST_WRITE_L;
         end
         ST_WRITE_L: begin
            cmd.wr_en = 1'b1;
            state_in  = ST_WRITE_R;
         end
         ST_WRITE_R: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_ch   = 1'b1;
            cmd.advance = 1'b1;
            cmd.clr_acc = 1'b1;
            tap_in      = '0;
            ch_in       = 1'b0;
            state_in    = ST_MAC;
         end
         ST_MAC: begin
            cmd.issue = 1'b1;
            if (tap_ff == TAP_BITS'(TAPS - 1)) begin
               tap_in = '0;
               ch_in  = 1'b1;
               if (ch_ff) begin
                  state_in = ST_DRAIN;
               end
            end else begin
               tap_in = tap_ff + TAP_BITS'(1);
            end
         end
         ST_DRAIN: begin
            // wait for the last products to land in the accumulators
            if (!status.busy) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== hw/rtl/upmix_dp.sv =====
// Datapath of the upmixer: registers, shared multiplier, accumulators, delay RAM.
module upmix_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write,
   input  logic [upmix_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [upmix_pkg::CSR_DATA_BITS-1:0]  csr_data,
   input  upmix_pkg::req_type                   req_data,
   input  upmix_pkg::cmd_type                   cmd,
   output upmix_pkg::status_type                status,
   output upmix_pkg::rsp_type                   rsp_data
);
   import upmix_pkg::*;

   logic [GAIN_BITS-1:0] left_gain_ff, right_gain_ff;
   logic                 enable_ff;
   logic [1:0]           mode_ff;

   sample_type l_ff, r_ff, fl_ff, fr_ff;
   sample_type ls_ff, rs_ff;
   logic       ls_clip_ff, rs_clip_ff;

   logic [TAP_BITS-1:0] ptr_ff, ptr_next, fill_ff;
   logic [TAP_BITS:0]   pos_wide;
   logic [TAP_BITS-1:0] pos;

   logic                rd_v_ff, rd_live_ff, rd_ch_ff;
   logic [TAP_BITS-1:0] rd_tap_ff;
   logic                mac_v_ff, mac_ch_ff;
   logic                gain_v_ff, gain_ch_ff;

   logic [SAMPLE_BITS-1:0]        ram_rdata;
   logic signed [SAMPLE_BITS-1:0] mul_a;
   logic signed [MUL_B_BITS-1:0]  mul_b;
   logic signed [PROD_BITS-1:0]   prod_ff, prod_in;
   logic signed [PROD_BITS-1:0]   gain_sum, gain_shift;
   logic signed [ACC_BITS-1:0]    acc_l_ff, acc_r_ff;
   logic signed [ACC_BITS-1:0]    fir_sum_l, fir_sum_r, fir_sh_l, fir_sh_r;
   sat_type                       fir_l, fir_r, center_sat, lfe_sat;
   logic [2:0]                    used;
   rsp_type                       rsp_in, rsp_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         left_gain_ff  <= GAIN_RESET;
         right_gain_ff <= GAIN_RESET;
         enable_ff     <= 1'b1;
         mode_ff       <= MODE_SIX;
      end else if (csr_write) begin
         case (csr_index)
            REG_LEFT_GAIN:   left_gain_ff  <= csr_data;
            REG_RIGHT_GAIN:  right_gain_ff <= csr_data;
            REG_ENABLE:      enable_ff     <= csr_data[0];
            REG_OUTPUT_MODE: mode_ff       <= csr_data[1:0];
            default: begin
            end
         endcase
      end
   end

   // circular delay lines: slot ptr_ff holds the newest sample
   assign ptr_next = (ptr_ff == TAP_BITS'(TAPS - 1)) ? '0 : ptr_ff + TAP_BITS'(1);

   always_comb begin
      if (ptr_ff >= cmd.tap) begin
         pos_wide = {1'b0, ptr_ff} - {1'b0, cmd.tap};
      end else begin
         pos_wide = {1'b0, ptr_ff} + (TAP_BITS + 1)'(TAPS) - {1'b0, cmd.tap};
      end
      pos = pos_wide[TAP_BITS-1:0];
   end

   upmix_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (RAM_DEPTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr ({cmd.wr_ch, ptr_next}),
      .wr_data (cmd.wr_ch ? fr_ff : fl_ff),
      .rd_en   (cmd.issue),
      .rd_addr ({cmd.rd_ch, pos}),
      .rd_data (ram_rdata)
   );

   // shared multiplier: gain products, then filter taps
   always_comb begin
      if (rd_v_ff) begin
         mul_a = rd_live_ff ? ram_rdata : '0;
         mul_b = MUL_B_BITS'(tap_coef(rd_tap_ff));
      end else begin
         mul_a = cmd.gain_ch ? r_ff : l_ff;
         mul_b = $signed(MUL_B_BITS'(cmd.gain_ch ? right_gain_ff : left_gain_ff));
      end
      prod_in = mul_a * mul_b;
   end

   assign gain_sum   = prod_ff + GAIN_HALF;
   assign gain_shift = gain_sum >>> GAIN_BITS;

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff    <= '0;
         fill_ff   <= '0;
         rd_v_ff   <= 1'b0;
         mac_v_ff  <= 1'b0;
         gain_v_ff <= 1'b0;
      end else begin
         rd_v_ff   <= cmd.issue;
         mac_v_ff  <= rd_v_ff;
         gain_v_ff <= cmd.gain;
         if (cmd.advance) begin
            ptr_ff <= ptr_next;
            if (fill_ff != TAP_BITS'(TAPS)) begin
               fill_ff <= fill_ff + TAP_BITS'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         l_ff <= req_data.left_in;
         r_ff <= req_data.right_in;
      end
      // entries never written since reset read as zero
      rd_live_ff <= (cmd.tap < fill_ff);
      rd_ch_ff   <= cmd.rd_ch;
      rd_tap_ff  <= cmd.tap;
      mac_ch_ff  <= rd_ch_ff;
      gain_ch_ff <= cmd.gain_ch;
      prod_ff    <= prod_in;
      if (gain_v_ff) begin
         if (gain_ch_ff) begin
            fr_ff <= gain_shift[SAMPLE_BITS-1:0];
         end else begin
            fl_ff <= gain_shift[SAMPLE_BITS-1:0];
         end
      end
      if (cmd.clr_acc) begin
         acc_l_ff <= '0;
         acc_r_ff <= '0;
      end else if (mac_v_ff) begin
         if (mac_ch_ff) begin
            acc_r_ff <= acc_r_ff + ACC_BITS'(prod_ff);
         end else begin
            acc_l_ff <= acc_l_ff + ACC_BITS'(prod_ff);
         end
      end
      if (cmd.scale) begin
         ls_ff      <= fir_l.value;
         ls_clip_ff <= fir_l.clip;
         rs_ff      <= fir_r.value;
         rs_clip_ff <= fir_r.clip;
      end
      if (cmd.load_out) begin
         rsp_ff <= rsp_in;
      end
   end

   assign fir_sum_l = acc_l_ff + FIR_HALF;
   assign fir_sum_r = acc_r_ff + FIR_HALF;
   assign fir_sh_l  = fir_sum_l >>> COEF_FRAC;
   assign fir_sh_r  = fir_sum_r >>> COEF_FRAC;
   assign fir_l     = sat_sample(fir_sh_l);
   assign fir_r     = sat_sample(fir_sh_r);

   assign center_sat = sat_sample(ACC_BITS'(fl_ff) + ACC_BITS'(fr_ff));
   assign lfe_sat    = sat_sample(ACC_BITS'(ls_ff) + ACC_BITS'(rs_ff));

   always_comb begin
      case (mode_ff)
         MODE_STEREO: used = CH_TWO;
         MODE_QUAD:   used = CH_FOUR;
         default:     used = CH_SIX;
      endcase

      rsp_in               = '0;
      rsp_in.channels_used = used;
      rsp_in.front_left    = l_ff;
      rsp_in.front_right   = r_ff;
      if (enable_ff) begin
         rsp_in.front_left  = fl_ff;
         rsp_in.front_right = fr_ff;
         if (used != CH_TWO) begin
            rsp_in.surround_left  = ls_ff;
            rsp_in.surround_right = rs_ff;
            rsp_in.clipped        = ls_clip_ff | rs_clip_ff;
         end
         if (used == CH_SIX) begin
            rsp_in.center_out   = center_sat.value;
            rsp_in.low_freq_out = lfe_sat.value;
            rsp_in.clipped      = ls_clip_ff | rs_clip_ff | center_sat.clip | lfe_sat.clip;
         end
      end
   end

   assign status.enable = enable_ff;
   assign status.busy   = rd_v_ff | mac_v_ff | gain_v_ff;
   assign rsp_data      = rsp_ff;

endmodule

// ===== hw/rtl/stereo_to_surround_upmix_fir.sv =====
// Top level of the stereo to 5.1 upmixer with FIR surround channels.
//
//   channel  handshake                 payload
//   req      req_valid / req_stall     req_data  (left_in, right_in)
//   rsp      rsp_valid / rsp_stall     rsp_data  (six channels, count, clip flag)
//   csr      csr_valid / csr_ready     csr_index, csr_data
//
// For an enabled request, one shared multiplier walks both delay lines tap by tap,
// one product per cycle. A request with enable at 0 leaves the delay lines alone.
// A fill count masks delay-line entries not yet written.
// A new request is taken while the previous result waits behind rsp_stall;
// the block holds in its last step only if that result is still not taken.
module stereo_to_surround_upmix_fir (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  upmix_pkg::req_type                   req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output upmix_pkg::rsp_type                   rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [upmix_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [upmix_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import upmix_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   upmix_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   upmix_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid & csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   // a new request never lands on a multiplier pipeline still in flight
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> !status.busy)
      else $error("request accepted while datapath busy");

   // gain products and tap reads never share the multiplier
   assert property (@(posedge clock) disable iff (reset)
      !(cmd.gain && cmd.issue))
      else $error("gain and tap read issued together");

   // stereo mode results carry no surround, center or LFE and no clip
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.channels_used == CH_TWO) |->
      (rsp_data.surround_left == '0 && rsp_data.surround_right == '0 &&
       rsp_data.center_out == '0 && rsp_data.low_freq_out == '0 && !rsp_data.clipped))
      else $error("stereo result has extra channels");

   // a result is loaded only when the output register is free
   assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid || !rsp_stall))
      else $error("result overwritten while stalled");
`endif

endmodule
